// ----- hdl/assert_macros.svh -----
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion shorthands used by the top level of the break scanner.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check cons in the same cycle whenever ante holds
`define FBS_ASSERT_IMP(name, clk, rst_n, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Check cons in the cycle after ante holds
`define FBS_ASSERT_NEXT(name, clk, rst_n, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- hdl/fbs_pkg.sv -----
// ----------------------------------------------------------------------------
// fbs_pkg
// Request codes, fixed constants and the structs passed between the scanner
// modules.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package fbs_pkg;

	// Request codes
	localparam logic [2:0] REQ_CHAR   = 3'd0;
	localparam logic [2:0] REQ_EOT    = 3'd1;
	localparam logic [2:0] REQ_WR_CAT = 3'd2;
	localparam logic [2:0] REQ_WR_TRN = 3'd3;
	localparam logic [2:0] REQ_WR_ACC = 3'd4;

	// Category value that marks an ignore character
	localparam logic [5:0] IGNORE_CAT = 6'h3F;

	// State numbers
	localparam int START_ST = 1;
	localparam int STOP_ST  = 0;

	// Break value reported for a scan that starts at end of text
	localparam logic [31:0] DONE_CODE = 32'hFFFF_FFFF;

	// Result buffer sizing
	localparam int OUT_DEPTH = 4;
	localparam int OUT_PTR_W = $clog2(OUT_DEPTH);
	localparam int OUT_CNT_W = OUT_PTR_W + 1;

	// One input item as it arrives
	typedef struct packed {
		logic [2:0]  req_type;
		logic [15:0] character;
		logic [31:0] position;
		logic [15:0] table_index;
		logic [5:0]  table_value;
		logic        ignore_mark;
	} fbs_req_t;

	// Scan item leaving the category lookup
	typedef struct packed {
		logic        vld;
		logic        is_char;
		logic        is_eot;
		logic [31:0] pos;
	} fbs_s1_t;

	// Table loads for the transition and accept stores
	typedef struct packed {
		logic        trn_we;
		logic        acc_we;
		logic [15:0] idx;
		logic [5:0]  val;
	} fbs_load_t;

	// One result item
	typedef struct packed {
		logic [31:0] break_position;
		logic        at_end;
	} fbs_result_t;

endpackage

// ----- hdl/fbs_channels.sv -----
// ----------------------------------------------------------------------------
// fbs_channels
// Valid/ready channels of the break scanner: request in, result out.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface fbs_req_if;
	logic        valid;
	logic        ready;
	logic [2:0]  req_type;
	logic [15:0] character;
	logic [31:0] position;
	logic [15:0] table_index;
	logic [5:0]  table_value;
	logic        ignore_mark;

	modport source (
		output valid, req_type, character, position, table_index, table_value,
			ignore_mark,
		input  ready
	);
	modport sink (
		input  valid, req_type, character, position, table_index, table_value,
			ignore_mark,
		output ready
	);
endinterface

interface fbs_rsp_if;
	logic        valid;
	logic        ready;
	logic [31:0] break_position;
	logic        at_end;

	modport source (
		output valid, break_position, at_end,
		input  ready
	);
	modport sink (
		input  valid, break_position, at_end,
		output ready
	);
endinterface

// ----- hdl/fbs_classify.sv -----
// ----------------------------------------------------------------------------
// fbs_classify
// Category table: loads entries and looks up the category of each accepted
// character, one synchronous read per item.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module fbs_classify import fbs_pkg::*; #(
	parameter int CHAR_W = 16
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       acc,
	input  fbs_req_t   item,
	output fbs_s1_t    item_s1,
	output logic [5:0] cat_s1
);

	localparam int CHAR_SPACE = 2 ** CHAR_W;

	logic [5:0] cat_mem [CHAR_SPACE];

	// Write a load entry, read the category of the incoming character
	always_ff @(posedge clk) begin
		if (acc && (item.req_type == REQ_WR_CAT)) begin
			cat_mem[item.table_index[CHAR_W-1:0]] <=
				item.ignore_mark ? IGNORE_CAT : item.table_value;
		end
		if (acc) begin
			cat_s1 <= cat_mem[item.character[CHAR_W-1:0]];
		end
	end

	// Advance scan items alongside the read
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			item_s1 <= '0;
		end else begin
			item_s1.is_char <= acc && (item.req_type == REQ_CHAR);
			item_s1.is_eot  <= acc && (item.req_type == REQ_EOT);
			item_s1.vld     <= acc && ((item.req_type == REQ_CHAR) ||
				(item.req_type == REQ_EOT));
			item_s1.pos     <= item.position;
		end
	end

endmodule

// ----- hdl/fbs_step.sv -----
// ----------------------------------------------------------------------------
// fbs_step
// Transition table and scan state. The state after the older item feeds the
// transition address of the next one, closing a read loop through the store.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module fbs_step import fbs_pkg::*; #(
	parameter int STATE_W = 6,
	parameter int CAT_W   = 5
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic [CAT_W:0]    stride,
	input  fbs_s1_t           item_s1,
	input  logic [5:0]        cat_s1,
	input  fbs_load_t         ld,
	output logic              s2_vld,
	output logic              push,
	output fbs_result_t       result
);

	localparam int TRN_W     = STATE_W + CAT_W;
	localparam int TRN_DEPTH = 2 ** TRN_W;
	localparam int MAX_ST    = 2 ** STATE_W;

	logic [STATE_W-1:0] trn_mem [TRN_DEPTH];
	logic [STATE_W-1:0] trn_rd_q;

	logic               char_s2;
	logic               eot_s2;
	logic               ign_s2;
	logic [31:0]        pos_p1_s2;

	logic [STATE_W-1:0] state_q;
	logic               active_q;
	logic [31:0]        pend_q;
	logic [MAX_ST-1:0]  acc_flags_q;

	logic               acc_we_s1;
	logic [STATE_W-1:0] acc_idx_s1;
	logic               acc_set_s1;

	logic [STATE_W-1:0] st_new;
	logic               stop;
	logic [31:0]        pend_new;
	logic               char_step;
	logic               eot_step;
	logic [STATE_W-1:0] state_nxt;
	logic               active_nxt;
	logic               rd_en;
	logic [TRN_W-1:0]   rd_addr;

	// Resolve the item in stage 2; an idle scan already holds the start state
	always_comb begin
		st_new    = ign_s2 ? state_q : trn_rd_q;
		stop      = (st_new == STATE_W'(STOP_ST));
		pend_new  = (acc_flags_q[st_new] || !active_q) ? pos_p1_s2 : pend_q;
		char_step = s2_vld && char_s2;
		eot_step  = s2_vld && eot_s2;

		if (char_step) begin
			state_nxt  = stop ? STATE_W'(START_ST) : st_new;
			active_nxt = !stop;
		end else if (eot_step) begin
			state_nxt  = STATE_W'(START_ST);
			active_nxt = 1'b0;
		end else begin
			state_nxt  = state_q;
			active_nxt = active_q;
		end
	end

	// Emit on a stop transition or end of text
	always_comb begin
		push = (char_step && stop) || eot_step;
		if (char_step) begin
			result.break_position = pend_new;
			result.at_end         = 1'b0;
		end else begin
			result.break_position = active_q ? pend_q : DONE_CODE;
			result.at_end         = !active_q;
		end
	end

	// Address the transition row of the state left by the older item
	assign rd_en   = item_s1.vld && item_s1.is_char && (cat_s1 != IGNORE_CAT);
	assign rd_addr = TRN_W'(state_nxt) * TRN_W'(stride) + TRN_W'(cat_s1);

	// Transition store: loads write, characters read (old data on a clash)
	always_ff @(posedge clk) begin
		if (ld.trn_we) begin
			trn_mem[ld.idx[TRN_W-1:0]] <= ld.val[STATE_W-1:0];
		end
		if (rd_en) begin
			trn_rd_q <= trn_mem[rd_addr];
		end
	end

	// Hold the offset of the break candidate
	always_ff @(posedge clk) begin
		pos_p1_s2 <= item_s1.pos + 32'd1;
	end

	// Advance the pipeline and the scan state; accept flag loads pass through a
	// register so that an older character still in stage 2 sees the old flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s2_vld      <= 1'b0;
			char_s2     <= 1'b0;
			eot_s2      <= 1'b0;
			ign_s2      <= 1'b0;
			state_q     <= STATE_W'(START_ST);
			active_q    <= 1'b0;
			pend_q      <= '0;
			acc_flags_q <= '0;
			acc_we_s1   <= 1'b0;
			acc_idx_s1  <= '0;
			acc_set_s1  <= 1'b0;
		end else begin
			s2_vld     <= item_s1.vld;
			char_s2    <= item_s1.is_char;
			eot_s2     <= item_s1.is_eot;
			ign_s2     <= (cat_s1 == IGNORE_CAT);
			state_q    <= state_nxt;
			active_q   <= active_nxt;
			acc_we_s1  <= ld.acc_we;
			acc_idx_s1 <= ld.idx[STATE_W-1:0];
			acc_set_s1 <= (ld.val != '0);
			if (char_step) begin
				pend_q <= pend_new;
			end
			if (acc_we_s1) begin
				acc_flags_q[acc_idx_s1] <= acc_set_s1;
			end
		end
	end

endmodule

// ----- hdl/fbs_out_fifo.sv -----
// ----------------------------------------------------------------------------
// fbs_out_fifo
// Small result buffer that decouples the scan pipeline from the consumer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module fbs_out_fifo import fbs_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	input  fbs_result_t          push_data,
	input  logic                 pop,
	output logic                 out_vld,
	output fbs_result_t          out_data,
	output logic [OUT_CNT_W-1:0] cnt
);

	fbs_result_t          buf_q [OUT_DEPTH];
	logic [OUT_PTR_W-1:0] wr_q;
	logic [OUT_PTR_W-1:0] rd_q;
	logic [OUT_CNT_W-1:0] cnt_q;

	assign out_vld  = (cnt_q != '0);
	assign out_data = buf_q[rd_q];
	assign cnt      = cnt_q;

	// Store pushed results
	always_ff @(posedge clk) begin
		if (push) begin
			buf_q[wr_q] <= push_data;
		end
	end

	// Advance pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= wr_q + 1'b1;
			end
			if (pop) begin
				rd_q <= rd_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

// ----- hdl/forward_break_dfa_scanner.sv -----
// ----------------------------------------------------------------------------
// forward_break_dfa_scanner
// Table-driven forward break scanner with loadable category, transition and
// accept tables.
// ----------------------------------------------------------------------------
// The scanner takes one item per clock cycle while req.ready is high, characters
// and table loads alike, and a result reaches rsp through the category read,
// the transition read and the result buffer. The sustained rate is set by the
// transition table loop: the state left by one character forms the transition
// address of the next in the same cycle. req.ready drops only when the
// four-entry result buffer together with the scan items still in flight could
// overflow, which happens only while the consumer holds off.
// The category and transition tables hold garbage after reset until loaded;
// accept flags reset to cleared and the category count resets to one.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module forward_break_dfa_scanner import fbs_pkg::*; #(
	parameter int CHAR_W  = 16,
	parameter int STATE_W = 6,
	parameter int CAT_W   = 5
) (
	input  logic       clk,
	input  logic       arst_n,
	fbs_req_if.sink    req,
	fbs_rsp_if.source  rsp,
	input  logic       cfg_we,
	input  logic [5:0] cfg_wdata
);

	localparam int MAX_CAT = 2 ** CAT_W;

	fbs_req_t             in_item;
	fbs_load_t            ld;
	fbs_s1_t              item_s1;
	logic [5:0]           cat_s1;
	logic                 s2_vld;
	logic                 push;
	fbs_result_t          push_data;
	fbs_result_t          out_data;
	logic                 out_vld;
	logic                 pop;
	logic [OUT_CNT_W-1:0] out_cnt;
	logic [OUT_CNT_W:0]   inflight;
	logic                 acc;
	logic [CAT_W:0]       stride_q;

	// Gather the request payload
	assign in_item.req_type    = req.req_type;
	assign in_item.character   = req.character;
	assign in_item.position    = req.position;
	assign in_item.table_index = req.table_index;
	assign in_item.table_value = req.table_value;
	assign in_item.ignore_mark = req.ignore_mark;

	// Reserve buffer room for every item that may still produce a result
	assign inflight  = (OUT_CNT_W+1)'(out_cnt) + (OUT_CNT_W+1)'(item_s1.vld)
		+ (OUT_CNT_W+1)'(s2_vld);
	assign req.ready = (inflight < (OUT_CNT_W+1)'(OUT_DEPTH));
	assign acc       = req.valid && req.ready;

	// Route table loads
	assign ld.trn_we = acc && (req.req_type == REQ_WR_TRN);
	assign ld.acc_we = acc && (req.req_type == REQ_WR_ACC);
	assign ld.idx    = req.table_index;
	assign ld.val    = req.table_value;

	// Hold the row stride (category count), clamped to one through MAX_CAT
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stride_q <= (CAT_W+1)'(1);
		end else if (cfg_we) begin
			if (cfg_wdata == '0) begin
				stride_q <= (CAT_W+1)'(1);
			end else if ({1'b0, cfg_wdata} > 7'(MAX_CAT)) begin
				stride_q <= (CAT_W+1)'(MAX_CAT);
			end else begin
				stride_q <= (CAT_W+1)'(cfg_wdata);
			end
		end
	end

	fbs_classify #(
		.CHAR_W (CHAR_W)
	) u_classify (
		.clk     (clk),
		.arst_n  (arst_n),
		.acc     (acc),
		.item    (in_item),
		.item_s1 (item_s1),
		.cat_s1  (cat_s1)
	);

	fbs_step #(
		.STATE_W (STATE_W),
		.CAT_W   (CAT_W)
	) u_step (
		.clk     (clk),
		.arst_n  (arst_n),
		.stride  (stride_q),
		.item_s1 (item_s1),
		.cat_s1  (cat_s1),
		.ld      (ld),
		.s2_vld  (s2_vld),
		.push    (push),
		.result  (push_data)
	);

	fbs_out_fifo u_out_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.pop       (pop),
		.out_vld   (out_vld),
		.out_data  (out_data),
		.cnt       (out_cnt)
	);

	// Drive the result channel
	assign pop                = out_vld && rsp.ready;
	assign rsp.valid          = out_vld;
	assign rsp.break_position = out_data.break_position;
	assign rsp.at_end         = out_data.at_end;

	// Checks
	`FBS_ASSERT_IMP(a_buf_bound, clk, arst_n, 1'b1, out_cnt <= OUT_CNT_W'(OUT_DEPTH), "result buffer overfilled")
	`FBS_ASSERT_IMP(a_no_push_full, clk, arst_n, push && !pop, out_cnt != OUT_CNT_W'(OUT_DEPTH), "push into full result buffer")
	`FBS_ASSERT_IMP(a_eot_result, clk, arst_n, acc && (req.req_type == REQ_EOT), ##2 push, "end of text gave no result")
	`FBS_ASSERT_IMP(a_done_code, clk, arst_n, rsp.valid && rsp.at_end, rsp.break_position == DONE_CODE, "done result without done code")

endmodule

// ----- dv/tb.sv -----
// ----------------------------------------------------------------------------
// tb
// Testbench for forward_break_dfa_scanner. Loads the category, transition and
// accept tables through request items. Scans characters and end-of-text items
// and checks every result item against a local table-driven break predictor.
// Random table contents, stride settings and traffic idling are used.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;
	import fbs_pkg::*;

	logic       clk;
	logic       arst_n;
	logic       cfg_we;
	logic [5:0] cfg_wdata;

	fbs_req_if req();
	fbs_rsp_if rsp();

	forward_break_dfa_scanner u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.req      (req),
		.rsp      (rsp),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata)
	);

	// Local copy of the scanner state
	logic [5:0]  cat_tbl [65536];
	logic [5:0]  next_state_tbl [2048];
	bit          trn_written [2048];
	bit          accept_tbl [64];
	logic [5:0]  cur_state   = 6'd1;
	logic [31:0] pending_brk = '0;
	bit          in_scan     = 1'b0;
	logic [5:0]  stride_reg  = 6'd1;

	fbs_result_t expected_breaks [$];
	logic [15:0] char_pool [$];
	logic [31:0] scan_pos;
	int          phase_states = 4;
	int          idle_pct     = 0;
	int          stall_pct    = 0;
	int          mismatch_cnt = 0;

	// Clock
	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// Stop a hung run
	initial begin
		#2_000_000;
		$display("Mismatches found");
		$finish;
	end

	// Effective row stride of the transition table
	function automatic int row_stride();
		if (stride_reg == 6'd0)
			return 1;
		if (stride_reg > 6'd32)
			return 32;
		return int'(stride_reg);
	endfunction

	function automatic logic [10:0] trn_addr(input logic [5:0] st, input logic [5:0] cat);
		return 11'((int'(st) * row_stride() + int'(cat)) % 2048);
	endfunction

	// Advance the local scanner by one accepted item
	function automatic void predict_break(input fbs_req_t it, output bit emits,
			output fbs_result_t res);
		logic [5:0] cat;
		emits = 1'b0;
		res = '0;
		case (it.req_type)
			REQ_CHAR: begin
				if (!in_scan) begin
					in_scan = 1'b1;
					cur_state = 6'(START_ST);
					pending_brk = it.position + 32'd1;
				end
				cat = cat_tbl[it.character];
				if (cat != IGNORE_CAT)
					cur_state = next_state_tbl[trn_addr(cur_state, cat)];
				if (accept_tbl[cur_state])
					pending_brk = it.position + 32'd1;
				if (cur_state == 6'(STOP_ST)) begin
					emits = 1'b1;
					res.break_position = pending_brk;
					res.at_end = 1'b0;
					in_scan = 1'b0;
					cur_state = 6'(START_ST);
				end
			end
			REQ_EOT: begin
				emits = 1'b1;
				if (in_scan) begin
					res.break_position = pending_brk;
					res.at_end = 1'b0;
					in_scan = 1'b0;
					cur_state = 6'(START_ST);
				end else begin
					res.break_position = DONE_CODE;
					res.at_end = 1'b1;
				end
			end
			REQ_WR_CAT: begin
				cat_tbl[it.table_index] = it.ignore_mark ? IGNORE_CAT : it.table_value;
			end
			REQ_WR_TRN: begin
				next_state_tbl[it.table_index[10:0]] = it.table_value;
				trn_written[it.table_index[10:0]] = 1'b1;
			end
			REQ_WR_ACC: begin
				accept_tbl[it.table_index[5:0]] = (it.table_value != 6'd0);
			end
			default: ;
		endcase
	endfunction

	// Send one item, with a random gap ahead of it, and record its result
	task automatic send_item(input fbs_req_t it);
		bit          emits;
		fbs_result_t res;
		if (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
			req.valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < idle_pct);
		end
		req.valid       <= 1'b1;
		req.req_type    <= it.req_type;
		req.character   <= it.character;
		req.position    <= it.position;
		req.table_index <= it.table_index;
		req.table_value <= it.table_value;
		req.ignore_mark <= it.ignore_mark;
		@(posedge clk);
		while (!req.ready) @(posedge clk);
		predict_break(it, emits, res);
		if (emits)
			expected_breaks.push_back(res);
	endtask

	// Item of the given kind with random filler in the fields it does not use
	function automatic fbs_req_t noise_item(input logic [2:0] kind);
		fbs_req_t it;
		it.req_type    = kind;
		it.character   = 16'($urandom);
		it.position    = $urandom_range(32'hFFFF_FFFE);
		it.table_index = 16'($urandom);
		it.table_value = 6'($urandom);
		it.ignore_mark = 1'($urandom);
		return it;
	endfunction

	task automatic send_char(input logic [15:0] ch, input logic [31:0] pos);
		fbs_req_t it;
		it = noise_item(REQ_CHAR);
		it.character = ch;
		it.position = pos;
		send_item(it);
	endtask

	task automatic send_eot();
		send_item(noise_item(REQ_EOT));
	endtask

	task automatic load_cat(input logic [15:0] ch, input logic [5:0] val, input bit ign);
		fbs_req_t it;
		it = noise_item(REQ_WR_CAT);
		it.table_index = ch;
		it.table_value = val;
		it.ignore_mark = ign;
		send_item(it);
	endtask

	task automatic load_trn(input logic [15:0] idx, input logic [5:0] val);
		fbs_req_t it;
		it = noise_item(REQ_WR_TRN);
		it.table_index = idx;
		it.table_value = val;
		send_item(it);
	endtask

	task automatic load_acc(input logic [15:0] idx, input logic [5:0] val);
		fbs_req_t it;
		it = noise_item(REQ_WR_ACC);
		it.table_index = idx;
		it.table_value = val;
		send_item(it);
	endtask

	// Hold off until all results are in and table loads have settled
	task automatic drain();
		req.valid <= 1'b0;
		@(posedge clk);
		while (expected_breaks.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic write_stride(input logic [5:0] n);
		drain();
		cfg_we    <= 1'b1;
		cfg_wdata <= n;
		@(posedge clk);
		cfg_we <= 1'b0;
		stride_reg = n;
	endtask

	task automatic close_scan();
		if (in_scan)
			send_eot();
	endtask

	task automatic set_traffic(input int sender_idle, input int receiver_stall);
		idle_pct  = sender_idle;
		stall_pct = receiver_stall;
	endtask

	// Next state for a table load: mostly within the phase's states
	function automatic logic [5:0] pick_next_state();
		if ($urandom_range(7) == 0)
			return 6'($urandom);
		return 6'($urandom_range(phase_states - 1));
	endfunction

	function automatic bit char_is_safe(input logic [15:0] ch);
		if (cat_tbl[ch] == IGNORE_CAT)
			return 1'b1;
		return trn_written[trn_addr(cur_state, cat_tbl[ch])];
	endfunction

	// Scan one pool character, loading a missing transition entry first
	task automatic send_scan_char();
		logic [15:0] ch;
		int          tries;
		if (!in_scan) begin
			case ($urandom_range(9))
				0:       scan_pos = 32'hFFFF_FFFE - $urandom_range(8);
				1:       scan_pos = $urandom_range(8);
				default: scan_pos = $urandom_range(32'hFFFF_FFFE);
			endcase
		end
		tries = 0;
		do begin
			ch = char_pool[$urandom_range(char_pool.size() - 1)];
			tries++;
		end while (!char_is_safe(ch) && tries < 8);
		if (!char_is_safe(ch))
			load_trn({5'($urandom), trn_addr(cur_state, cat_tbl[ch])}, pick_next_state());
		send_char(ch, scan_pos);
		scan_pos += $urandom_range(1, 2);
		if (scan_pos == 32'hFFFF_FFFF)
			scan_pos = '0;
	endtask

	// Fresh tables and stride, then a random mix of scans, ends of text and loads
	task automatic random_phase(input int n_cols, input int n_states, input int n_items);
		logic [15:0] ch;
		int          roll;
		close_scan();
		write_stride(6'(n_cols));
		phase_states = n_states;
		char_pool.delete();

		// Category entries: mostly in range, some past the stride, some ignored
		repeat ($urandom_range(16, 40)) begin
			ch = 16'($urandom);
			case ($urandom_range(9))
				7:       load_cat(ch, 6'($urandom_range(62)), 1'b0);
				8:       load_cat(ch, 6'($urandom), 1'b1);
				9:       load_cat(ch, IGNORE_CAT, 1'b0);
				default: load_cat(ch, 6'($urandom_range(n_cols - 1)), 1'b0);
			endcase
			char_pool.push_back(ch);
		end

		// Full transition rows for the phase's states
		for (int s = 0; s < n_states; s++) begin
			for (int c = 0; c < n_cols; c++)
				load_trn({5'($urandom), trn_addr(6'(s), 6'(c))},
					6'($urandom_range(n_states - 1)));
		end

		for (int s = 0; s < n_states; s++)
			load_acc({10'($urandom), 6'(s)},
				$urandom_range(1) ? 6'($urandom_range(1, 63)) : 6'd0);

		repeat (n_items) begin
			roll = $urandom_range(99);
			if (roll < 7) begin
				send_eot();
			end else if (roll < 12) begin
				// Rewrite a table entry, often in the middle of a scan
				case ($urandom_range(2))
					0: load_cat(char_pool[$urandom_range(char_pool.size() - 1)],
						6'($urandom), 1'($urandom));
					1: load_trn(16'($urandom), pick_next_state());
					default: load_acc(16'($urandom), 6'($urandom));
				endcase
			end else begin
				send_scan_char();
			end
		end
		close_scan();
	endtask

	// End of text with no scan open reports done
	task automatic test_done_at_idle();
		send_eot();
		send_eot();
	endtask

	// Hand-built tables: ignore forms, stride overlap, stop state, offset extremes
	task automatic test_directed_scans();
		write_stride(6'd2);
		load_cat(16'h0000, 6'd0, 1'b0);
		load_cat(16'hFFFF, 6'd1, 1'b0);
		load_cat(16'h0041, 6'h15, 1'b1);
		load_cat(16'h0042, IGNORE_CAT, 1'b0);
		load_cat(16'h0043, 6'd3, 1'b0);
		load_trn(16'hF802, 6'd2);
		load_trn(16'h0004, 6'd2);
		load_trn(16'h0005, 6'd0);
		load_acc(16'hFFC2, 6'd63);
		load_acc(16'h0000, 6'd1);

		// Accept, ignore with accept, then stop in an accepting stop state
		send_char(16'h0000, 32'd0);
		send_char(16'h0041, 32'd1);
		send_char(16'hFFFF, 32'd2);

		// Ignore at the top offset, closed by end of text
		send_char(16'h0042, 32'hFFFF_FFFE);
		send_eot();

		// Category past the stride lands on the stop entry
		send_char(16'h0043, 32'd100);
		load_acc(16'h0040, 6'd0);

		// Clear an accept flag in the middle of a scan
		send_char(16'h0000, 32'd200);
		send_char(16'h0000, 32'd201);
		load_acc(16'hFFC2, 6'd0);
		send_char(16'h0000, 32'd202);
		send_char(16'hFFFF, 32'd203);
	endtask

	// Smallest and largest stride
	task automatic test_stride_extremes();
		set_traffic(0, 0);
		random_phase(1, 4, 60);
		set_traffic(26, 26);
		random_phase(32, 2, 60);
	endtask

	// Random tables under each idling pattern
	task automatic test_idle_modes();
		set_traffic(0, 0);
		random_phase($urandom_range(2, 31), $urandom_range(3, 4), 70);
		set_traffic(57, 0);
		random_phase($urandom_range(2, 31), $urandom_range(3, 4), 70);
		set_traffic(0, 57);
		random_phase($urandom_range(2, 31), $urandom_range(3, 4), 70);
		set_traffic(26, 26);
		random_phase($urandom_range(2, 31), $urandom_range(3, 4), 70);
	endtask

	// Random stalls on the result side
	always @(posedge clk) begin
		rsp.ready <= ($urandom_range(99) >= stall_pct);
	end

	// Compare each result item with the oldest expected break
	always @(posedge clk) begin
		fbs_result_t want;
		if (arst_n && rsp.valid && rsp.ready) begin
			if (expected_breaks.size() == 0) begin
				$error("unexpected result item: break_position %0h at_end %0b",
					rsp.break_position, rsp.at_end);
				mismatch_cnt++;
			end else begin
				want = expected_breaks.pop_front();
				if (rsp.break_position !== want.break_position) begin
					$error("break_position: expected %0h, got %0h",
						want.break_position, rsp.break_position);
					mismatch_cnt++;
				end
				if (rsp.at_end !== want.at_end) begin
					$error("at_end: expected %0b, got %0b", want.at_end, rsp.at_end);
					mismatch_cnt++;
				end
			end
		end
	end

	// Reset, run the tests, drain and report
	initial begin
		arst_n          <= 1'b0;
		cfg_we          <= 1'b0;
		cfg_wdata       <= '0;
		req.valid       <= 1'b0;
		req.req_type    <= REQ_CHAR;
		req.character   <= '0;
		req.position    <= '0;
		req.table_index <= '0;
		req.table_value <= '0;
		req.ignore_mark <= 1'b0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_done_at_idle();
		test_directed_scans();
		test_stride_extremes();
		test_idle_modes();

		drain();
		if (mismatch_cnt == 0 && expected_breaks.size() == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule

// ----- sim.f -----
+incdir+hdl
hdl/fbs_pkg.sv
hdl/fbs_channels.sv
hdl/fbs_classify.sv
hdl/fbs_step.sv
hdl/fbs_out_fifo.sv
hdl/forward_break_dfa_scanner.sv
dv/tb.sv
